@@ hdl/tftp_read_session_engine_macros.svh @@
// assertion macros for the tftp read session engine
`ifndef TFTP_READ_SESSION_ENGINE_MACROS_SVH
`define TFTP_READ_SESSION_ENGINE_MACROS_SVH
// implication checked on every clock unless in reset
`define TRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hdl/trse_pkg.sv @@
`default_nettype none
package trse_pkg;
  localparam int unsigned SESSIONS = 8;
  localparam int unsigned SLOT_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam logic [9:0] BLOCK_BYTES = 10'd512;
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_RRQ = 3'd0, OP_ACK = 3'd1, OP_ERR = 3'd2, OP_OTHER = 3'd3, OP_TICK = 3'd4,
    OP_U5 = 3'd5, OP_U6 = 3'd6, OP_U7 = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0, ACT_RESEND = 2'd1, ACT_ERROR = 2'd2, ACT_CLOSE = 2'd3
  } action_t;

  localparam logic [2:0] ERR_UNDEF = 3'd0;
  localparam logic [2:0] ERR_NOFILE = 3'd1;
  localparam logic [2:0] ERR_ACCESS = 3'd2;
  localparam logic [2:0] ERR_ILLEGAL = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN = 3'd5;

  localparam logic [1:0] CHK_OK = 2'd0;
  localparam logic [1:0] CHK_PARENT = 2'd1;
  localparam logic [1:0] CHK_MODE = 2'd2;
  localparam logic [1:0] CHK_MISSING = 2'd3;

  localparam logic CFG_MAX_RETRIES = 1'b0;
  localparam logic CFG_IDLE_LIMIT = 1'b1;

  typedef struct packed {
    op_t         op;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [15:0] acked_block;
    logic [1:0]  request_check;
    logic [9:0]  chunk_len;
  } req_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [15:0] block_out;
    logic [9:0]  payload_len;
    logic [2:0]  err_code;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_TICK, ST_EMIT
  } state_t;
endpackage
`default_nettype wire

@@ hdl/trse_if.sv @@
`default_nettype none
interface trse_req_if (input wire logic clk);
  logic valid;
  logic ready;
  trse_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trse_res_if (input wire logic clk);
  logic valid;
  logic ready;
  trse_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/tftp_read_session_engine.sv @@
// tftp read session engine
// in_ channel: one event per transaction (read request, ack, client error,
//   other packet, one-second tick) on a valid/ready handshake
// out_ channel: result transactions, the final one of an event has last set
// cfg_ port: write enable, index (0 max_retries, 1 idle_limit) and data
// the front takes events into a two-entry queue, the back works one event
// at a time against an eight-slot session table, one slot per cycle save
// while an expiring tick slot waits for the output register
// a packet passes the queue, a scan of all eight slots and a decide step that
// waits for the output register; a tick is popped, sweeps all eight slots and
// wraps up, waiting for each expiry result that finds the output register busy
// a tick with no expiry gives no result
// reset clears all sessions, the queue and the output register, and loads
// max_retries 3 and idle_limit 5
// if the receiver stalls the back holds the result and pauses; the queue
// fills and in_ready drops
`default_nettype none
module tftp_read_session_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  trse_req_if.sink         in_ch,
  trse_res_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);
  logic [3:0] max_retries_r;
  logic [7:0] idle_limit_r;
  trse_pkg::req_t q_data;
  logic q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r <= 4'd3;
      idle_limit_r <= 8'd5;
    end else if (cfg_we) begin
      if (cfg_index == trse_pkg::CFG_MAX_RETRIES) begin
        max_retries_r <= cfg_data[3:0];
      end else begin
        idle_limit_r <= cfg_data;
      end
    end
  end

  trse_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  trse_back u_back (
    .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .max_retries(max_retries_r), .idle_limit(idle_limit_r), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

@@ hdl/trse_front.sv @@
`default_nettype none
// chunk clamp and two-entry event queue
module trse_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  trse_req_if.sink            in_ch,
  output trse_pkg::req_t      q_data,
  output logic                q_valid,
  input  wire logic           q_pop
);
  trse_pkg::req_t mem_r [trse_pkg::QDEPTH];
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  trse_pkg::req_t in_fix;
  logic push;

  always_comb begin
    in_fix = in_ch.data;
    if (in_ch.data.chunk_len > trse_pkg::BLOCK_BYTES) begin
      in_fix.chunk_len = trse_pkg::BLOCK_BYTES;
    end
  end

  assign in_ch.ready = (cnt_r != 2'(trse_pkg::QDEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = mem_r[rd_r];

  always_comb begin
    rd_nxt = rd_r ^ q_pop;
    wr_nxt = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_r] <= in_fix;
    end
  end
endmodule
`default_nettype wire

@@ hdl/trse_back.sv @@
`default_nettype none
`include "tftp_read_session_engine_macros.svh"
// session table and sequencer: one slot examined per cycle, except while an expiring tick slot waits for the output
module trse_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  trse_pkg::req_t      q_data,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire logic [3:0]     max_retries,
  input  wire logic [7:0]     idle_limit,
  trse_res_if.source          out_ch
);
  localparam int unsigned S = trse_pkg::SESSIONS;
  localparam int unsigned W = trse_pkg::SLOT_W;

  logic [S-1:0] valid_r, valid_nxt;
  logic [31:0] addr_r [S];
  logic [15:0] port_r [S];
  logic [15:0] blk_r [S];
  logic [3:0]  ret_r [S];
  logic        fin_r [S];
  logic [7:0]  idle_r [S];

  trse_pkg::state_t st_r, st_nxt;
  trse_pkg::req_t cur_r, cur_nxt;
  logic [W-1:0] idx_r, idx_nxt;
  logic hit_r, hit_nxt, fre_r, fre_nxt;
  logic [W-1:0] hidx_r, hidx_nxt, fidx_r, fidx_nxt;
  logic [3:0] emitted_r, emitted_nxt;
  trse_pkg::res_t o_r, o_nxt;
  logic ov_r, ov_nxt;

  // slot write request
  logic wr_en;
  logic [W-1:0] wr_idx;
  logic [31:0] wr_addr;
  logic [15:0] wr_port, wr_blk;
  logic [3:0] wr_ret;
  logic wr_fin;
  logic [7:0] wr_idle;

  logic last_idx;
  logic [7:0] inc_idle;
  trse_pkg::res_t r;

  // slots that would expire on this tick, and whether one lies past the cursor
  logic [S-1:0] exp_mask;
  logic more_exp;

  assign out_ch.valid = ov_r;
  assign out_ch.data = o_r;
  assign last_idx = (idx_r == W'(S - 1));
  assign inc_idle = (idle_r[idx_r] == 8'hFF) ? 8'hFF : idle_r[idx_r] + 8'd1;

  always_comb begin
    more_exp = 1'b0;
    for (int i = 0; i < S; i++) begin
      exp_mask[i] = valid_r[i] &&
                    (((idle_r[i] == 8'hFF) ? 8'hFF : idle_r[i] + 8'd1) >= idle_limit);
      if (W'(i) > idx_r && exp_mask[i]) begin
        more_exp = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= trse_pkg::ST_IDLE;
      valid_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      valid_r <= valid_nxt;
      ov_r <= ov_nxt;
    end
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    fre_r <= fre_nxt;
    hidx_r <= hidx_nxt;
    fidx_r <= fidx_nxt;
    emitted_r <= emitted_nxt;
    o_r <= o_nxt;
    if (wr_en) begin
      addr_r[wr_idx] <= wr_addr;
      port_r[wr_idx] <= wr_port;
      blk_r[wr_idx] <= wr_blk;
      ret_r[wr_idx] <= wr_ret;
      fin_r[wr_idx] <= wr_fin;
      idle_r[wr_idx] <= wr_idle;
    end
  end

  always_comb begin
    st_nxt = st_r;
    cur_nxt = cur_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r;
    fre_nxt = fre_r;
    hidx_nxt = hidx_r;
    fidx_nxt = fidx_r;
    emitted_nxt = emitted_r;
    o_nxt = o_r;
    ov_nxt = ov_r;
    valid_nxt = valid_r;
    q_pop = 1'b0;
    wr_en = 1'b0;
    wr_idx = hidx_r;
    wr_addr = addr_r[hidx_r];
    wr_port = port_r[hidx_r];
    wr_blk = blk_r[hidx_r];
    wr_ret = ret_r[hidx_r];
    wr_fin = fin_r[hidx_r];
    wr_idle = idle_r[hidx_r];
    r = '0;
    r.dest_addr = cur_r.peer_addr;
    r.dest_port = cur_r.peer_port;
    r.last = 1'b1;
    if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      trse_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cur_nxt = q_data;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          fre_nxt = 1'b0;
          emitted_nxt = '0;
          st_nxt = (q_data.op == trse_pkg::OP_TICK) ? trse_pkg::ST_TICK
                                                    : trse_pkg::ST_SCAN;
        end
      end
      trse_pkg::ST_SCAN: begin
        if (valid_r[idx_r] && addr_r[idx_r] == cur_r.peer_addr &&
            port_r[idx_r] == cur_r.peer_port && !hit_r) begin
          hit_nxt = 1'b1;
          hidx_nxt = idx_r;
        end
        if (!valid_r[idx_r] && !fre_r) begin
          fre_nxt = 1'b1;
          fidx_nxt = idx_r;
        end
        idx_nxt = idx_r + W'(1);
        if (last_idx) begin
          st_nxt = trse_pkg::ST_DECIDE;
        end
      end
      trse_pkg::ST_DECIDE: begin
        // wait until the output register is free
        if (!ov_r || out_ch.ready) begin
          st_nxt = trse_pkg::ST_IDLE;
          ov_nxt = 1'b1;
          r.action = trse_pkg::ACT_ERROR;
          priority case (cur_r.op)
            trse_pkg::OP_RRQ: begin
              if (hit_r) begin
                if (blk_r[hidx_r] != 16'd1) begin
                  r.err_code = trse_pkg::ERR_ILLEGAL;
                  valid_nxt[hidx_r] = 1'b0;
                end else if (ret_r[hidx_r] >= max_retries) begin
                  r.err_code = trse_pkg::ERR_UNDEF;
                  valid_nxt[hidx_r] = 1'b0;
                end else begin
                  wr_en = 1'b1;
                  wr_ret = (ret_r[hidx_r] == 4'hF) ? 4'hF : ret_r[hidx_r] + 4'd1;
                  r.action = trse_pkg::ACT_RESEND;
                  r.block_out = 16'd1;
                end
              end else if (cur_r.request_check == trse_pkg::CHK_PARENT) begin
                r.err_code = trse_pkg::ERR_ACCESS;
              end else if (cur_r.request_check == trse_pkg::CHK_MODE) begin
                r.err_code = trse_pkg::ERR_ILLEGAL;
              end else if (cur_r.request_check == trse_pkg::CHK_MISSING) begin
                r.err_code = trse_pkg::ERR_NOFILE;
              end else if (!fre_r) begin
                r.err_code = trse_pkg::ERR_UNDEF;
              end else begin
                wr_en = 1'b1;
                wr_idx = fidx_r;
                wr_addr = cur_r.peer_addr;
                wr_port = cur_r.peer_port;
                wr_blk = 16'd1;
                wr_ret = 4'd0;
                wr_idle = 8'd0;
                wr_fin = cur_r.chunk_len < trse_pkg::BLOCK_BYTES;
                valid_nxt[fidx_r] = 1'b1;
                r.action = trse_pkg::ACT_SEND;
                r.block_out = 16'd1;
                r.payload_len = cur_r.chunk_len;
              end
            end
            trse_pkg::OP_ACK: begin
              if (!hit_r) begin
                r.err_code = trse_pkg::ERR_UNKNOWN;
              end else begin
                wr_en = 1'b1;
                wr_idle = 8'd0;
                if (blk_r[hidx_r] != cur_r.acked_block) begin
                  if (ret_r[hidx_r] >= max_retries) begin
                    r.err_code = trse_pkg::ERR_UNDEF;
                    valid_nxt[hidx_r] = 1'b0;
                  end else begin
                    wr_ret = (ret_r[hidx_r] == 4'hF) ? 4'hF : ret_r[hidx_r] + 4'd1;
                    r.action = trse_pkg::ACT_RESEND;
                    r.block_out = blk_r[hidx_r];
                  end
                end else if (fin_r[hidx_r]) begin
                  r.action = trse_pkg::ACT_CLOSE;
                  valid_nxt[hidx_r] = 1'b0;
                end else begin
                  wr_ret = 4'd0;
                  wr_blk = (blk_r[hidx_r] == 16'hFFFF) ? 16'd1 : blk_r[hidx_r] + 16'd1;
                  wr_fin = cur_r.chunk_len < trse_pkg::BLOCK_BYTES;
                  r.action = trse_pkg::ACT_SEND;
                  r.block_out = wr_blk;
                  r.payload_len = cur_r.chunk_len;
                end
              end
            end
            trse_pkg::OP_ERR: begin
              if (hit_r) begin
                r.action = trse_pkg::ACT_CLOSE;
                valid_nxt[hidx_r] = 1'b0;
              end else begin
                ov_nxt = out_ch.ready ? 1'b0 : ov_r;
              end
            end
            default: begin
              r.err_code = trse_pkg::ERR_ACCESS;
            end
          endcase
          if (ov_nxt) begin
            o_nxt = r;
          end
        end
      end
      trse_pkg::ST_TICK: begin
        // one slot per cycle; an expiring slot waits for the output register
        if (!valid_r[idx_r]) begin
          idx_nxt = idx_r + W'(1);
          if (last_idx) begin
            st_nxt = trse_pkg::ST_EMIT;
          end
        end else if (inc_idle >= idle_limit && emitted_r != 4'd8) begin
          if (!ov_r || out_ch.ready) begin
            wr_en = 1'b1;
            wr_idx = idx_r;
            wr_addr = addr_r[idx_r];
            wr_port = port_r[idx_r];
            wr_blk = blk_r[idx_r];
            wr_ret = ret_r[idx_r];
            wr_fin = fin_r[idx_r];
            wr_idle = inc_idle;
            valid_nxt[idx_r] = 1'b0;
            r.action = trse_pkg::ACT_ERROR;
            r.err_code = trse_pkg::ERR_UNDEF;
            r.dest_addr = addr_r[idx_r];
            r.dest_port = port_r[idx_r];
            // last when no later slot expires or the result cap is reached
            r.last = !more_exp || (emitted_r == 4'd7);
            o_nxt = r;
            ov_nxt = 1'b1;
            emitted_nxt = emitted_r + 4'd1;
            idx_nxt = idx_r + W'(1);
            if (last_idx) begin
              st_nxt = trse_pkg::ST_EMIT;
            end
          end
        end else begin
          wr_en = 1'b1;
          wr_idx = idx_r;
          wr_addr = addr_r[idx_r];
          wr_port = port_r[idx_r];
          wr_blk = blk_r[idx_r];
          wr_ret = ret_r[idx_r];
          wr_fin = fin_r[idx_r];
          wr_idle = inc_idle;
          idx_nxt = idx_r + W'(1);
          if (last_idx) begin
            st_nxt = trse_pkg::ST_EMIT;
          end
        end
      end
      trse_pkg::ST_EMIT: begin
        // tick sweep done
        st_nxt = trse_pkg::ST_IDLE;
      end
      default: begin
        st_nxt = trse_pkg::ST_IDLE;
      end
    endcase
  end

  `TRS_ASSERT_NXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
  `TRS_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, st_r == trse_pkg::ST_IDLE && q_valid, "pop outside idle")
  `TRS_ASSERT_IMP(a_tick_cap, clk, rst_n, st_r == trse_pkg::ST_TICK, emitted_r <= 4'd8, "too many tick results")
endmodule
`default_nettype wire
